>>> rtl/positional_doubly_linked_list_core_defines.svh
// assertion macros for the positional doubly linked list core
// no dependencies; included by the files that carry assertions
`ifndef POSITIONAL_DOUBLY_LINKED_LIST_CORE_DEFINES_SVH
`define POSITIONAL_DOUBLY_LINKED_LIST_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PDLL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdll assertion failed");
`define PDLL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdll assertion failed");
`else
`define PDLL_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PDLL_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/pdll_pkg.sv
// package for the positional doubly linked list core: sizes, codes, word types
// no dependencies
`default_nettype none

package pdll_pkg;

	localparam int CAPACITY    = 256;
	localparam int VALUE_WIDTH = 32;
	localparam int SLOT_W      = $clog2(CAPACITY);
	localparam int LINK_W      = $clog2(CAPACITY + 1);
	localparam int POS_W       = 9;
	localparam int DATA_W      = 32;

	localparam logic [LINK_W-1:0] NIL_SLOT = LINK_W'(CAPACITY);

	typedef enum logic [1:0] {
		CMD_INSERT,
		CMD_DELETE,
		CMD_SEARCH,
		CMD_NOP
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_BAD_POS,
		STAT_EMPTY,
		STAT_FULL
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ALLOC,
		ST_WALK,
		ST_LINK,
		ST_DEL_UPD,
		ST_SEARCH
	} state_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic                     found;
		logic signed [DATA_W-1:0] removed_value;
		logic [POS_W-1:0]         element_count;
	} rsp_t;

endpackage

`default_nettype wire

>>> rtl/pdll_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module pdll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/positional_doubly_linked_list_core.sv
// top level of the positional doubly linked list core
// depends on pdll_pkg, pdll_ram and positional_doubly_linked_list_core_defines.svh
//
// usage:
//   a command word (req: cmd, position, value) is taken at a rising edge with
//   start high and busy low. busy stays high while the command runs. one
//   result word (rsp) is shown for exactly one cycle with done high; busy is
//   low in that cycle, so the next command may be started alongside it.
//   the receiver cannot stall the result.
// sequence, from accept to done:
//   every command passes decode; error and unused codes end there. insert at
//   head, tail or into an empty list goes through alloc and link; delete at
//   head or tail through del_upd. a middle delete walks before del_upd and a
//   middle insert walks between alloc and link, one link followed per cycle on
//   the next-link memory read port; search compares one entry per cycle.
// reset:
//   the list comes up empty with every slot free. the free-slot memory is not
//   cleared: a low-water mark tells entries never written apart, so no
//   clearing pass is needed and a command may start right after reset.
`default_nettype none
`include "positional_doubly_linked_list_core_defines.svh"

module positional_doubly_linked_list_core import pdll_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	state_t state_q, state_d;

	cmd_t                   cmd_q;
	logic [POS_W-1:0]       pos_q;
	logic [VALUE_WIDTH-1:0] val_q;

	logic [LINK_W-1:0] head_q, head_d;
	logic [LINK_W-1:0] tail_q, tail_d;
	logic [LINK_W-1:0] count_q, count_d;
	logic [LINK_W-1:0] free_top_q, free_top_d;
	logic [LINK_W-1:0] low_q, low_d;
	logic [LINK_W-1:0] a_q, a_d;
	logic [LINK_W-1:0] b_q, b_d;
	logic [SLOT_W-1:0] n_q, n_d;
	logic [SLOT_W-1:0] d_q, d_d;
	logic [POS_W-1:0]  walk_q, walk_d;
	rsp_t              rsp_q, rsp_d;
	logic              done_q, done_d;

	logic                   val_we, nxt_we, prv_we, fre_we;
	logic [SLOT_W-1:0]      val_waddr, nxt_waddr, prv_waddr, fre_waddr;
	logic [SLOT_W-1:0]      val_raddr, nxt_raddr, prv_raddr, fre_raddr;
	logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;
	logic [LINK_W-1:0]      nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;
	logic [SLOT_W-1:0]      fre_wdata, fre_rdata;

	logic [LINK_W-1:0] pop_idx;
	logic [SLOT_W-1:0] n_alloc;
	logic              head_nil, pos_zero, pos_gt_cnt, pos_eq_cnt, pos_last;
	logic              list_full, ins_mid, walk_done, val_match, nxt_nil;

	pdll_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
		.raddr(val_raddr), .rdata(val_rdata)
	);

	pdll_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next_ram (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(nxt_raddr), .rdata(nxt_rdata)
	);

	pdll_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prev_ram (
		.clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
		.raddr(prv_raddr), .rdata(prv_rdata)
	);

	pdll_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
		.clk(clk), .we(fre_we), .waddr(fre_waddr), .wdata(fre_wdata),
		.raddr(fre_raddr), .rdata(fre_rdata)
	);

	assign pop_idx    = free_top_q - LINK_W'(1);
	// free stack entries below the low-water mark were never written; their own index stands in for them
	assign n_alloc    = (pop_idx < low_q) ? pop_idx[SLOT_W-1:0] : fre_rdata;
	assign head_nil   = (head_q == NIL_SLOT);
	assign pos_zero   = (pos_q == '0);
	assign pos_gt_cnt = (32'(pos_q) > 32'(count_q));
	assign pos_eq_cnt = (32'(pos_q) == 32'(count_q));
	assign pos_last   = ((32'(pos_q) + 32'd1) == 32'(count_q));
	assign list_full  = (32'(count_q) >= 32'(CAPACITY)) || (free_top_q == '0);
	assign ins_mid    = !head_nil && !pos_zero && !pos_eq_cnt;
	assign walk_done  = (walk_q == pos_q);
	assign val_match  = (val_rdata == val_q);
	assign nxt_nil    = (nxt_rdata == NIL_SLOT);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (cmd_q)
					CMD_INSERT: begin
						if (pos_gt_cnt || list_full) begin
							state_d = ST_IDLE;
						end else begin
							state_d = ST_ALLOC;
						end
					end
					CMD_DELETE: begin
						if (head_nil || (count_q == '0) || pos_gt_cnt || pos_eq_cnt) begin
							state_d = ST_IDLE;
						end else if (pos_zero || pos_last) begin
							state_d = ST_DEL_UPD;
						end else begin
							state_d = ST_WALK;
						end
					end
					CMD_SEARCH: begin
						state_d = head_nil ? ST_IDLE : ST_SEARCH;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_ALLOC: begin
				state_d = ins_mid ? ST_WALK : ST_LINK;
			end
			ST_WALK: begin
				if (walk_done) begin
					state_d = (cmd_q == CMD_DELETE) ? ST_DEL_UPD : ST_LINK;
				end
			end
			ST_LINK: begin
				state_d = ST_IDLE;
			end
			ST_DEL_UPD: begin
				state_d = ST_IDLE;
			end
			ST_SEARCH: begin
				if (val_match || nxt_nil) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory ports and datapath
	always_comb begin
		val_we     = 1'b0;
		val_waddr  = '0;
		val_wdata  = '0;
		val_raddr  = '0;
		nxt_we     = 1'b0;
		nxt_waddr  = '0;
		nxt_wdata  = '0;
		nxt_raddr  = '0;
		prv_we     = 1'b0;
		prv_waddr  = '0;
		prv_wdata  = '0;
		prv_raddr  = '0;
		fre_we     = 1'b0;
		fre_waddr  = '0;
		fre_wdata  = '0;
		fre_raddr  = '0;
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		free_top_d = free_top_q;
		low_d      = low_q;
		a_d        = a_q;
		b_d        = b_q;
		n_d        = n_q;
		d_d        = d_q;
		walk_d     = walk_q;
		rsp_d      = rsp_q;
		done_d     = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
			end
			ST_DECODE: begin
				rsp_d.status        = STAT_OK;
				rsp_d.found         = 1'b0;
				rsp_d.removed_value = '0;
				unique case (cmd_q)
					CMD_INSERT: begin
						if (pos_gt_cnt) begin
							rsp_d.status = STAT_BAD_POS;
							done_d       = 1'b1;
						end else if (list_full) begin
							rsp_d.status = STAT_FULL;
							done_d       = 1'b1;
						end else begin
							fre_raddr = pop_idx[SLOT_W-1:0];
							if (head_nil) begin
								a_d = NIL_SLOT;
								b_d = NIL_SLOT;
							end else if (pos_zero) begin
								a_d = NIL_SLOT;
								b_d = head_q;
							end else if (pos_eq_cnt) begin
								a_d = tail_q;
								b_d = NIL_SLOT;
							end else begin
								a_d = head_q;
							end
						end
					end
					CMD_DELETE: begin
						if (head_nil || (count_q == '0)) begin
							rsp_d.status = STAT_EMPTY;
							done_d       = 1'b1;
						end else if (pos_gt_cnt || pos_eq_cnt) begin
							rsp_d.status = STAT_BAD_POS;
							done_d       = 1'b1;
						end else if (pos_zero || pos_last) begin
							d_d       = pos_zero ? head_q[SLOT_W-1:0] : tail_q[SLOT_W-1:0];
							val_raddr = d_d;
							nxt_raddr = d_d;
							prv_raddr = d_d;
						end else begin
							nxt_raddr = head_q[SLOT_W-1:0];
							walk_d    = POS_W'(1);
						end
					end
					CMD_SEARCH: begin
						if (head_nil) begin
							done_d = 1'b1;
						end else begin
							val_raddr = head_q[SLOT_W-1:0];
							nxt_raddr = head_q[SLOT_W-1:0];
						end
					end
					default: begin
						done_d = 1'b1;
					end
				endcase
			end
			ST_ALLOC: begin
				n_d        = n_alloc;
				free_top_d = pop_idx;
				if (pop_idx < low_q) begin
					low_d = pop_idx;
				end
				val_we    = 1'b1;
				val_waddr = n_alloc;
				val_wdata = val_q;
				if (ins_mid) begin
					nxt_raddr = head_q[SLOT_W-1:0];
					walk_d    = POS_W'(1);
				end else begin
					nxt_we    = 1'b1;
					nxt_waddr = n_alloc;
					nxt_wdata = b_q;
					prv_we    = 1'b1;
					prv_waddr = n_alloc;
					prv_wdata = a_q;
				end
			end
			ST_WALK: begin
				nxt_raddr = nxt_rdata[SLOT_W-1:0];
				prv_raddr = nxt_rdata[SLOT_W-1:0];
				val_raddr = nxt_rdata[SLOT_W-1:0];
				if (walk_done) begin
					if (cmd_q == CMD_DELETE) begin
						d_d = nxt_rdata[SLOT_W-1:0];
					end else begin
						b_d       = nxt_rdata;
						nxt_we    = 1'b1;
						nxt_waddr = n_q;
						nxt_wdata = nxt_rdata;
						prv_we    = 1'b1;
						prv_waddr = n_q;
						prv_wdata = a_q;
					end
				end else begin
					a_d    = nxt_rdata;
					walk_d = walk_q + POS_W'(1);
				end
			end
			ST_LINK: begin
				if (b_q != NIL_SLOT) begin
					prv_we    = 1'b1;
					prv_waddr = b_q[SLOT_W-1:0];
					prv_wdata = LINK_W'(n_q);
				end
				if (a_q != NIL_SLOT) begin
					nxt_we    = 1'b1;
					nxt_waddr = a_q[SLOT_W-1:0];
					nxt_wdata = LINK_W'(n_q);
				end
				head_d  = (a_q == NIL_SLOT) ? LINK_W'(n_q) : head_q;
				tail_d  = (b_q == NIL_SLOT) ? LINK_W'(n_q) : tail_q;
				count_d = count_q + LINK_W'(1);
				done_d  = 1'b1;
			end
			ST_DEL_UPD: begin
				if (prv_rdata != NIL_SLOT) begin
					nxt_we    = 1'b1;
					nxt_waddr = prv_rdata[SLOT_W-1:0];
					nxt_wdata = nxt_rdata;
				end
				if (nxt_rdata != NIL_SLOT) begin
					prv_we    = 1'b1;
					prv_waddr = nxt_rdata[SLOT_W-1:0];
					prv_wdata = prv_rdata;
				end
				head_d = (prv_rdata == NIL_SLOT) ? nxt_rdata : head_q;
				tail_d = (nxt_rdata == NIL_SLOT) ? prv_rdata : tail_q;
				if (free_top_q < LINK_W'(CAPACITY)) begin
					fre_we     = 1'b1;
					fre_waddr  = free_top_q[SLOT_W-1:0];
					fre_wdata  = d_q;
					free_top_d = free_top_q + LINK_W'(1);
				end
				rsp_d.removed_value = DATA_W'($signed(val_rdata));
				count_d             = count_q - LINK_W'(1);
				done_d              = 1'b1;
			end
			ST_SEARCH: begin
				if (val_match) begin
					rsp_d.found = 1'b1;
					done_d      = 1'b1;
				end else if (nxt_nil) begin
					done_d = 1'b1;
				end else begin
					val_raddr = nxt_rdata[SLOT_W-1:0];
					nxt_raddr = nxt_rdata[SLOT_W-1:0];
				end
			end
			default: begin
			end
		endcase

		if (done_d) begin
			rsp_d.element_count = POS_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= NIL_SLOT;
			tail_q     <= NIL_SLOT;
			count_q    <= '0;
			free_top_q <= LINK_W'(CAPACITY);
			low_q      <= LINK_W'(CAPACITY);
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			count_q    <= count_d;
			free_top_q <= free_top_d;
			low_q      <= low_d;
			done_q     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && (state_q == ST_IDLE)) begin
			cmd_q <= req.cmd;
			pos_q <= req.position;
			val_q <= VALUE_WIDTH'(req.value);
		end
		a_q    <= a_d;
		b_q    <= b_d;
		n_q    <= n_d;
		d_q    <= d_d;
		walk_q <= walk_d;
		rsp_q  <= rsp_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	`PDLL_ASSERT_IMP(a_slots_conserved, clk, arst_n, (state_q == ST_IDLE), ((LINK_W+1)'(count_q) + (LINK_W+1)'(free_top_q) == (LINK_W+1)'(CAPACITY)))
	`PDLL_ASSERT_IMP(a_head_tail_empty, clk, arst_n, 1'b1, (((head_q == NIL_SLOT) == (count_q == '0)) && ((tail_q == NIL_SLOT) == (count_q == '0))))
	`PDLL_ASSERT_IMP(a_low_water, clk, arst_n, 1'b1, (low_q <= free_top_q))
	`PDLL_ASSERT_NEXT(a_start_busy, clk, arst_n, (start && !busy), busy)
	`PDLL_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)

endmodule

`default_nettype wire

>>> tb/positional_doubly_linked_list_core_tb.sv
// self-checking testbench for positional_doubly_linked_list_core: directed and random commands
// depends on pdll_pkg and the core; predicts each result word from a queue model of the list
`default_nettype none

module positional_doubly_linked_list_core_tb;
	import pdll_pkg::*;

	localparam int WORD_TARGET = 850;
	localparam int QUIET_TAIL  = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	req_t pending_words[$];
	rsp_t expected_rsp[$];
	int list_model[$];
	int value_pool[$];
	int gen_count = 0;
	int words_sent = 0;
	int words_taken = 0;
	int total_words = 0;
	int error_count = 0;
	int gap_left = 0;
	int idle_stop = 0;
	logic took = 1'b0;

	positional_doubly_linked_list_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic rsp_t apply_command(req_t w);
		rsp_t r;
		int n;
		r = '0;
		n = list_model.size();
		case (w.cmd)
			CMD_INSERT: begin
				if (w.position > n)
					r.status = STAT_BAD_POS;
				else if (n >= CAPACITY)
					r.status = STAT_FULL;
				else
					list_model.insert(w.position, w.value);
			end
			CMD_DELETE: begin
				if (n == 0) begin
					r.status = STAT_EMPTY;
				end else if (w.position >= n) begin
					r.status = STAT_BAD_POS;
				end else begin
					r.removed_value = list_model[w.position];
					list_model.delete(w.position);
				end
			end
			CMD_SEARCH: begin
				foreach (list_model[i])
					if (list_model[i] == w.value)
						r.found = 1'b1;
			end
			default: begin
			end
		endcase
		r.element_count = POS_W'(list_model.size());
		return r;
	endfunction

	task automatic check_field(string field_name, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s expected %0h actual %0h", $time, field_name, want_v, got_v);
			error_count++;
		end
	endtask

	task automatic emit_word(cmd_t c, int pos, int val);
		req_t w;
		w.cmd = c;
		w.position = POS_W'(pos);
		w.value = val;
		pending_words.push_back(w);
		case (c)
			CMD_INSERT: begin
				if (pos <= gen_count && gen_count < CAPACITY) begin
					gen_count++;
					value_pool.push_back(val);
					if (value_pool.size() > 64)
						void'(value_pool.pop_front());
				end
			end
			CMD_DELETE: begin
				if (pos < gen_count)
					gen_count--;
			end
			default: begin
			end
		endcase
	endtask

	function automatic int draw_value(int pool_pct);
		int k;
		k = $urandom_range(0, 99);
		if (k < pool_pct && value_pool.size() > 0)
			return value_pool[$urandom_range(0, value_pool.size() - 1)];
		if (k >= 97)
			return int'(32'h7fff_ffff);
		if (k >= 94)
			return int'(32'h8000_0000);
		if (k >= 91)
			return int'($urandom_range(0, 3)) - 2;
		return int'($urandom);
	endfunction

	// monitor: check result words, then predict the word taken at this edge
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: result word expected none actual %h", $time, rsp);
					error_count++;
				end else begin
					want = expected_rsp.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("found", want.found, rsp.found);
					check_field("removed_value", want.removed_value, rsp.removed_value);
					check_field("element_count", want.element_count, rsp.element_count);
				end
			end
			if (start && !busy) begin
				expected_rsp.push_back(apply_command(req));
				words_taken++;
			end
		end
		took <= arst_n && start && !busy;
	end

	// driver: hold a word until taken, then gap or present the next one
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || took) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_words.size() == 0) begin
				start <= 1'b0;
			end else if (words_sent < idle_stop && words_sent % 128 < 96
					&& $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				gap_left <= $urandom_range(0, 4);
			end else begin
				req <= pending_words.pop_front();
				start <= 1'b1;
				words_sent <= words_sent + 1;
			end
		end
	end

	initial begin
		int roll;
		int target;
		int top;

		// directed: empty list, head, tail and middle cases, bad positions, unused code
		emit_word(CMD_DELETE, 0, 0);
		emit_word(CMD_SEARCH, 0, 0);
		emit_word(CMD_NOP, 0, 7);
		emit_word(CMD_INSERT, 1, 3);
		emit_word(CMD_INSERT, 0, int'(32'h8000_0000));
		emit_word(CMD_INSERT, 1, int'(32'h7fff_ffff));
		emit_word(CMD_INSERT, 0, -1);
		emit_word(CMD_INSERT, 1, 0);
		emit_word(CMD_INSERT, 4, 5);
		emit_word(CMD_SEARCH, 0, int'(32'h8000_0000));
		emit_word(CMD_SEARCH, 511, int'(32'h7fff_ffff));
		emit_word(CMD_SEARCH, 0, 12345);
		emit_word(CMD_INSERT, 6, 9);
		emit_word(CMD_INSERT, 511, 9);
		emit_word(CMD_DELETE, 5, 0);
		emit_word(CMD_DELETE, 511, 0);
		emit_word(CMD_DELETE, 2, 0);
		emit_word(CMD_DELETE, 0, 0);
		emit_word(CMD_DELETE, 2, 0);
		emit_word(CMD_NOP, 511, -1);
		emit_word(CMD_DELETE, 0, 0);
		emit_word(CMD_DELETE, 0, 0);
		emit_word(CMD_DELETE, 0, 0);
		emit_word(CMD_SEARCH, 0, int'(32'h7fff_ffff));

		// fill to capacity, probe the full list, then drain
		while (gen_count < CAPACITY) begin
			roll = $urandom_range(0, 3);
			if (roll == 0)
				emit_word(CMD_INSERT, 0, draw_value(5));
			else if (roll == 1)
				emit_word(CMD_INSERT, gen_count, draw_value(5));
			else
				emit_word(CMD_INSERT, $urandom_range(0, gen_count), draw_value(5));
		end
		emit_word(CMD_INSERT, 0, 1);
		emit_word(CMD_INSERT, CAPACITY, 1);
		emit_word(CMD_INSERT, CAPACITY + 1, 1);
		emit_word(CMD_INSERT, 511, 1);
		emit_word(CMD_SEARCH, 0, draw_value(100));
		emit_word(CMD_SEARCH, 0, draw_value(0));
		emit_word(CMD_DELETE, CAPACITY, 0);
		emit_word(CMD_DELETE, CAPACITY - 1, 0);
		emit_word(CMD_INSERT, CAPACITY - 1, draw_value(20));
		emit_word(CMD_INSERT, 3, 1);
		while (gen_count > 0) begin
			if ($urandom_range(0, 99) < 12)
				emit_word(CMD_SEARCH, $urandom_range(0, 511), draw_value(60));
			else
				emit_word(CMD_DELETE, $urandom_range(0, gen_count - 1), 0);
		end

		// random mix around a drifting list size
		target = 8;
		while (pending_words.size() < WORD_TARGET) begin
			if ($urandom_range(0, 59) == 0)
				target = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 48);
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				emit_word(CMD_NOP, $urandom_range(0, 511), int'($urandom));
			end else if (roll < 8) begin
				top = (gen_count + 1 > 511) ? 511 : gen_count + 1;
				emit_word(CMD_INSERT, $urandom_range(top, 511), draw_value(10));
			end else if (roll < 12) begin
				emit_word(CMD_DELETE, $urandom_range(gen_count, 511), int'($urandom));
			end else if (roll < 27) begin
				emit_word(CMD_SEARCH, $urandom_range(0, 511), draw_value(60));
			end else if ((gen_count < target) == ($urandom_range(0, 3) != 0)
					|| gen_count == 0) begin
				emit_word(CMD_INSERT, $urandom_range(0, gen_count), draw_value(15));
			end else begin
				emit_word(CMD_DELETE, $urandom_range(0, gen_count - 1), int'($urandom));
			end
		end

		total_words = pending_words.size();
		idle_stop = total_words - QUIET_TAIL;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_taken < total_words)
			@(negedge clk);
		while (expected_rsp.size() != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);

		if (error_count == 0 && expected_rsp.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#(12 * 1_500_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/pdll_pkg.sv
rtl/pdll_ram.sv
rtl/positional_doubly_linked_list_core.sv
tb/positional_doubly_linked_list_core_tb.sv
